// ===== hdl/mbb_pkg.sv =====
// Shared types, sizes and codes for the message byte buffer.
// No dependencies; every other file refers to it by scoped names.
`default_nettype none

package mbb_pkg;

    localparam int BUFFER_BYTES = 1024;
    localparam int POS_W        = $clog2(BUFFER_BYTES + 1);
    localparam int CAP_W        = 11;
    localparam int FILL_W       = 11;
    localparam int CALC_W       = ((POS_W > CAP_W) ? POS_W : CAP_W) + 1;
    localparam int LANES        = 4;
    localparam int BANK_DEPTH   = (BUFFER_BYTES + LANES - 1) / LANES;
    localparam int BANK_AW      = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam int CFG_DW       = 32;
    localparam int CFG_AW       = 3;

    localparam logic REG_CAPACITY = 1'b0;
    localparam logic REG_ALLOW    = 1'b1;
    localparam logic [CAP_W-1:0] CAPACITY_RESET = CAP_W'(1024);

    typedef enum logic [1:0] {
        OP_BEGIN_WRITE = 2'd0,
        OP_WRITE       = 2'd1,
        OP_BEGIN_READ  = 2'd2,
        OP_READ        = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        SZ_BYTE = 2'd0,
        SZ_HALF = 2'd1,
        SZ_WORD = 2'd2
    } t_size;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_UNDERRUN = 2'd1,
        ST_WRAPPED  = 2'd2,
        ST_REFUSED  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_READ = 2'd1,
        S_OUT  = 2'd2
    } t_state;

    typedef struct packed {
        logic [CAP_W-1:0] capacity;
        logic             allow;
    } t_cfg;

    typedef struct packed {
        logic accept;    // load the beat on the input side
        logic assemble;  // bank read data is valid, build the read value
    } t_cmd;

    typedef struct packed {
        logic in_is_read;
    } t_sts;

    // bytes moved by a size code; zero for the unused code
    function automatic logic [2:0] size_len(input logic [1:0] code);
        logic [2:0] len;
        unique case (code)
            SZ_BYTE: len = 3'd1;
            SZ_HALF: len = 3'd2;
            SZ_WORD: len = 3'd4;
            default: len = 3'd0;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/mbb_regs.sv =====
// Configuration registers behind a small APB-style port.
// Depends on mbb_pkg.
`default_nettype none

module mbb_regs (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [mbb_pkg::CFG_AW-1:0]  paddr,
    input  wire logic [mbb_pkg::CFG_DW-1:0]  pwdata,
    output logic      [mbb_pkg::CFG_DW-1:0]  prdata,
    output logic                             pready,
    output mbb_pkg::t_cfg                    o_cfg
);

    logic [mbb_pkg::CAP_W-1:0] r_capacity;
    logic                      r_allow;
    logic                      wr_hit;

    assign pready = 1'b1;
    assign wr_hit = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= mbb_pkg::CAPACITY_RESET;
            r_allow    <= 1'b0;
        end else if (wr_hit) begin
            unique case (paddr[2])
                mbb_pkg::REG_CAPACITY: r_capacity <= pwdata[mbb_pkg::CAP_W-1:0];
                mbb_pkg::REG_ALLOW:    r_allow    <= pwdata[0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            mbb_pkg::REG_CAPACITY: prdata = mbb_pkg::CFG_DW'(r_capacity);
            mbb_pkg::REG_ALLOW:    prdata = mbb_pkg::CFG_DW'(r_allow);
        endcase
    end

    assign o_cfg.capacity = r_capacity;
    assign o_cfg.allow    = r_allow;

endmodule

`default_nettype wire

// ===== hdl/mbb_ctrl.sv =====
// Controller FSM: sequences accept, bank read and result hold.
// Depends on mbb_pkg.
`default_nettype none

module mbb_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_s_tvalid,
    input  wire logic          i_m_tready,
    input  wire mbb_pkg::t_sts i_sts,
    output logic               o_s_tready,
    output logic               o_m_tvalid,
    output mbb_pkg::t_cmd      o_cmd
);

    mbb_pkg::t_state r_state;
    mbb_pkg::t_state n_state;
    logic            take;

    // a held result leaving this cycle frees the block for a new beat
    assign take = i_s_tvalid &
                  ((r_state == mbb_pkg::S_IDLE) | ((r_state == mbb_pkg::S_OUT) & i_m_tready));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mbb_pkg::S_IDLE: begin
                if (take) n_state = i_sts.in_is_read ? mbb_pkg::S_READ : mbb_pkg::S_OUT;
            end
            mbb_pkg::S_READ: begin
                n_state = mbb_pkg::S_OUT;
            end
            mbb_pkg::S_OUT: begin
                if (take) n_state = i_sts.in_is_read ? mbb_pkg::S_READ : mbb_pkg::S_OUT;
                else if (i_m_tready) n_state = mbb_pkg::S_IDLE;
            end
            default: n_state = mbb_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_s_tready      = (r_state == mbb_pkg::S_IDLE) |
                          ((r_state == mbb_pkg::S_OUT) & i_m_tready);
        o_m_tvalid      = (r_state == mbb_pkg::S_OUT);
        o_cmd.accept    = o_s_tready & i_s_tvalid;
        o_cmd.assemble  = (r_state == mbb_pkg::S_READ);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= mbb_pkg::S_IDLE;
        else          r_state <= n_state;
    end

endmodule

`default_nettype wire

// ===== hdl/mbb_datapath.sv =====
// Datapath: pointers, overflow flag, four byte-lane banks and the result register.
// Depends on mbb_pkg; driven by mbb_ctrl commands.
`default_nettype none

module mbb_datapath (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire mbb_pkg::t_cmd               i_cmd,
    input  wire mbb_pkg::t_cfg               i_cfg,
    input  wire logic [1:0]                  i_operation,
    input  wire logic [1:0]                  i_size_code,
    input  wire logic [31:0]                 i_write_value,
    output mbb_pkg::t_sts                    o_sts,
    output logic [31:0]                      o_read_value,
    output logic [1:0]                       o_status,
    output logic                             o_overflowed,
    output logic [mbb_pkg::FILL_W-1:0]       o_fill_level
);

    localparam int PW = mbb_pkg::POS_W;
    localparam int CW = mbb_pkg::CALC_W;
    localparam int AW = mbb_pkg::BANK_AW;

    logic [PW-1:0] r_wp, n_wp;
    logic [PW-1:0] r_rp, n_rp;
    logic          r_ovf, n_ovf;

    logic [31:0]   r_read_value;
    logic [1:0]    r_status;
    logic          r_rd_ok;
    logic [1:0]    r_lane0;
    logic [1:0]    r_size;

    logic [2:0]    len;
    logic [CW-1:0] cap;
    logic [CW-1:0] wp_end, rp_end;
    logic [PW-1:0] wr_start;
    logic          wr_en;
    logic          rd_ok;
    logic [31:0]   rv;
    mbb_pkg::t_status st;

    logic [7:0]    bank_q [mbb_pkg::LANES];
    logic [31:0]   packed_q;
    logic [31:0]   assembled;

    assign len    = mbb_pkg::size_len(i_size_code);
    assign wp_end = CW'(r_wp) + CW'(len);
    assign rp_end = CW'(r_rp) + CW'(len);
    assign o_sts.in_is_read = (mbb_pkg::t_op'(i_operation) == mbb_pkg::OP_READ);

    // capacity above the buffer saturates
    always_comb begin
        if (CW'(i_cfg.capacity) > CW'(mbb_pkg::BUFFER_BYTES)) cap = CW'(mbb_pkg::BUFFER_BYTES);
        else                                                   cap = CW'(i_cfg.capacity);
    end

    always_comb begin
        n_wp     = r_wp;
        n_rp     = r_rp;
        n_ovf    = r_ovf;
        st       = mbb_pkg::ST_OK;
        rv       = '0;
        wr_en    = 1'b0;
        wr_start = r_wp;
        rd_ok    = 1'b0;
        unique case (mbb_pkg::t_op'(i_operation))
            mbb_pkg::OP_BEGIN_WRITE: begin
                n_wp  = '0;
                n_ovf = 1'b0;
            end
            mbb_pkg::OP_WRITE: begin
                if ((len == 3'd0) || (CW'(len) > cap)) begin
                    st = mbb_pkg::ST_REFUSED;
                end else if ((wp_end > cap) && !i_cfg.allow) begin
                    st = mbb_pkg::ST_REFUSED;
                end else begin
                    wr_en = 1'b1;
                    if (wp_end > cap) begin
                        wr_start = '0;
                        n_ovf    = 1'b1;
                        st       = mbb_pkg::ST_WRAPPED;
                    end
                    n_wp = PW'(CW'(wr_start) + CW'(len));
                end
            end
            mbb_pkg::OP_BEGIN_READ: begin
                n_rp = '0;
            end
            mbb_pkg::OP_READ: begin
                if ((len == 3'd0) || (rp_end > CW'(r_wp))) begin
                    rv = '1;
                    st = mbb_pkg::ST_UNDERRUN;
                end else begin
                    rd_ok = 1'b1;
                    n_rp  = PW'(rp_end);
                end
            end
        endcase
    end

    // byte k of a beat sits in lane (start + k) mod 4
    for (genvar b = 0; b < mbb_pkg::LANES; b++) begin : g_bank
        logic [7:0]    r_mem [mbb_pkg::BANK_DEPTH];
        logic [7:0]    r_q;
        logic [1:0]    wk, rk;
        logic [CW-1:0] wa, ra;
        logic          we;

        assign wk = 2'(b) - wr_start[1:0];
        assign rk = 2'(b) - r_rp[1:0];
        assign wa = CW'(wr_start) + CW'(wk);
        assign ra = CW'(r_rp) + CW'(rk);
        assign we = i_cmd.accept & wr_en & (3'(wk) < len);

        always_ff @(posedge i_clk) begin
            if (we) r_mem[wa[AW+1:2]] <= i_write_value[{wk, 3'b000} +: 8];
            if (i_cmd.accept & rd_ok) r_q <= r_mem[ra[AW+1:2]];
        end

        assign bank_q[b] = r_q;
    end

    always_comb begin
        for (int k = 0; k < mbb_pkg::LANES; k++) begin
            packed_q[8*k +: 8] = bank_q[2'(r_lane0 + 2'(k))];
        end
        unique case (r_size)
            mbb_pkg::SZ_BYTE: assembled = {24'd0, packed_q[7:0]};
            mbb_pkg::SZ_HALF: assembled = {{16{packed_q[15]}}, packed_q[15:0]};
            default:          assembled = packed_q;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_ovf <= 1'b0;
        end else if (i_cmd.accept) begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_ovf <= n_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_read_value <= rv;
            r_status     <= st;
            r_rd_ok      <= rd_ok;
            r_lane0      <= r_rp[1:0];
            r_size       <= i_size_code;
        end else if (i_cmd.assemble && r_rd_ok) begin
            r_read_value <= assembled;
        end
    end

    assign o_read_value = r_read_value;
    assign o_status     = r_status;
    assign o_overflowed = r_ovf;
    assign o_fill_level = mbb_pkg::FILL_W'(r_wp);

endmodule

`default_nettype wire

// ===== hdl/message_byte_buffer.sv =====
// Top level of the message byte buffer: config registers, controller, datapath.
// Depends on mbb_pkg, mbb_regs, mbb_ctrl, mbb_datapath.
//
//   channel   dir   handshake               payload
//   s         in    i_s_tvalid/o_s_tready   tuser: operation, size_code; tdata: write_value
//   m         out   o_m_tvalid/i_m_tready   tuser: status; tdata: read_value, overflowed, fill
//   apb       in    psel/penable/pready     capacity_in_use @0x0, allow_overflow @0x4
//
// Non-read beats: result in the cycle after accept; with the sink ready, one beat per cycle.
// Read beats: the registered read of the four byte-lane banks is assembled in S_READ, then shown in S_OUT.
// Reset clears pointers, overflow flag and controller; bank contents are left as they are.
// A held result stalls new reads/writes only while the sink holds tready low.
`default_nettype none

module message_byte_buffer (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_s_tvalid,
    output logic                             o_s_tready,
    input  wire logic [31:0]                 i_s_tdata,   // [31:0] write_value
    input  wire logic [3:0]                  i_s_tuser,   // [1:0] operation, [3:2] size_code
    output logic                             o_m_tvalid,
    input  wire logic                        i_m_tready,
    output logic      [47:0]                 o_m_tdata,   // [31:0] read_value, [32] overflowed,
                                                          // [43:33] fill_level, [47:44] zero
    output logic      [1:0]                  o_m_tuser,   // [1:0] status
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [mbb_pkg::CFG_AW-1:0]  paddr,
    input  wire logic [mbb_pkg::CFG_DW-1:0]  pwdata,
    output logic      [mbb_pkg::CFG_DW-1:0]  prdata,
    output logic                             pready
);

    mbb_pkg::t_cfg cfg;
    mbb_pkg::t_cmd cmd;
    mbb_pkg::t_sts sts;

    logic [31:0]                 read_value;
    logic [1:0]                  status;
    logic                        overflowed;
    logic [mbb_pkg::FILL_W-1:0]  fill_level;

    mbb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    mbb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_m_tready (i_m_tready),
        .i_sts      (sts),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_cmd      (cmd)
    );

    mbb_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_cfg         (cfg),
        .i_operation   (i_s_tuser[1:0]),
        .i_size_code   (i_s_tuser[3:2]),
        .i_write_value (i_s_tdata),
        .o_sts         (sts),
        .o_read_value  (read_value),
        .o_status      (status),
        .o_overflowed  (overflowed),
        .o_fill_level  (fill_level)
    );

    assign o_m_tdata = {4'd0, fill_level, overflowed, read_value};
    assign o_m_tuser = status;

    // never take a beat while a result is stuck at the output
    a_no_accept_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_tready && o_m_tvalid && !i_m_tready))
        else $error("input taken while result is held");

    a_wrap_sets_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (mbb_pkg::t_status'(status) == mbb_pkg::ST_WRAPPED)) |-> overflowed)
        else $error("wrapped write without overflow flag");

    a_underrun_all_ones: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (mbb_pkg::t_status'(status) == mbb_pkg::ST_UNDERRUN))
            |-> (read_value == 32'hFFFF_FFFF))
        else $error("underrun result is not -1");

    a_fill_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (32'(fill_level) <= 32'(mbb_pkg::BUFFER_BYTES)))
        else $error("fill level beyond buffer");

endmodule

`default_nettype wire
